// ===== hw/rtl/stes_pkg.sv =====
// Package for the sorted table exact search block: defaults, port widths, command codes, sequencer states.
package stes_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 256;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   localparam int CMD_WIDTH        = 1;
   localparam int INDEX_WIDTH      = 8;
   localparam int KEY_WIDTH        = 32;
   localparam int COUNT_REG_WIDTH  = 9;
   localparam int POSITION_WIDTH   = 8;

   localparam logic [CMD_WIDTH-1:0] CMD_WRITE  = 1'b0;
   localparam logic [CMD_WIDTH-1:0] CMD_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE
   } state_type;

endpackage

// ===== hw/rtl/stes_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module stes_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sorted_table_exact_search_top.sv =====
// Top level of the sorted table exact search block: table RAM and binary search sequencer.
//
//   channel   ports                                      handshake
//   request   req_cmd, req_entry_index, req_entry_value, start / busy, taken at start && !busy
//             req_key
//   response  rsp_found, rsp_position                   rsp_valid strobe, one cycle
//   config    csr_wr_data                               csr_wr_en, write at the edge
//
// A write item goes to the table RAM when it is taken and leaves busy low.
// A search item stays busy through ST_PROBE then ST_COMPARE for each probe, ending from
// ST_COMPARE on a hit or from ST_PROBE after p probes that miss, p at most floor(log2(n)) + 1
// for n entries in use; each probe is one RAM read with registered data followed by one compare.
// Synchronous active-high reset clears the sequencer and entries_in_use; the table holds
// garbage until written.
// The receiver cannot stall: rsp_valid is high for exactly one cycle per result; rsp_found and rsp_position hold.
module sorted_table_exact_search_top
   import stes_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [CMD_WIDTH-1:0]              req_cmd,
   input  logic [INDEX_WIDTH-1:0]            req_entry_index,
   input  logic signed [KEY_WIDTH-1:0]       req_entry_value,
   input  logic signed [KEY_WIDTH-1:0]       req_key,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic [POSITION_WIDTH-1:0]         rsp_position,
   input  logic                              csr_wr_en,
   input  logic [COUNT_REG_WIDTH-1:0]        csr_wr_data
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   state_type state_ff, state_in;

   logic [COUNT_REG_WIDTH-1:0] entries_in_use_ff;
   logic [CNT_W-1:0]           lo_ff, lo_in;
   logic [CNT_W-1:0]           end_ff, end_in;
   logic [ADDR_W-1:0]          mid_ff, mid_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [POSITION_WIDTH-1:0]  rsp_position_ff, rsp_position_in;

   logic                       accept;
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic signed [VALUE_WIDTH-1:0] wr_value;
   logic [VALUE_WIDTH-1:0]     rd_data;
   logic signed [VALUE_WIDTH-1:0] probe;
   logic [CNT_W-1:0]           count;
   logic [CNT_W:0]             mid_sum;
   logic [ADDR_W-1:0]          mid_calc;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign wr_addr  = ADDR_W'(req_entry_index);
   assign wr_value = VALUE_WIDTH'(req_entry_value);
   assign wr_en    = accept && (req_cmd == CMD_WRITE)
                     && (32'(req_entry_index) < TABLE_DEPTH);
   assign probe    = $signed(rd_data);

   assign count    = (32'(entries_in_use_ff) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                            : CNT_W'(entries_in_use_ff);
   assign mid_sum  = (CNT_W + 1)'(lo_ff) + (CNT_W + 1)'(end_ff) - (CNT_W + 1)'(1);
   assign mid_calc = ADDR_W'(mid_sum[CNT_W:1]);

   stes_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_value),
      .rd_addr (mid_calc),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         entries_in_use_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            entries_in_use_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff           <= lo_in;
      end_ff          <= end_in;
      mid_ff          <= mid_in;
      key_ff          <= key_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   always_comb begin
      state_in        = state_ff;
      lo_in           = lo_ff;
      end_in          = end_ff;
      mid_in          = mid_ff;
      key_in          = key_ff;
      rsp_valid_in    = 1'b0;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_SEARCH)) begin
               key_in   = VALUE_WIDTH'(req_key);
               lo_in    = '0;
               end_in   = count;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (lo_ff < end_ff) begin
               mid_in   = mid_calc;
               state_in = ST_COMPARE;
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b0;
               rsp_position_in = '0;
               state_in        = ST_IDLE;
            end
         end
         ST_COMPARE: begin
            if (probe == key_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b1;
               rsp_position_in = POSITION_WIDTH'(mid_ff);
               state_in        = ST_IDLE;
            end else begin
               if (key_ff > probe) begin
                  lo_in = CNT_W'(mid_ff) + CNT_W'(1);
               end else begin
                  end_in = CNT_W'(mid_ff);
               end
               state_in = ST_PROBE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a search in flight");

   a_done_with_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("search ended without a result");

   a_miss_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_position == '0))
      else $error("miss reports a nonzero position");

   a_live_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPARE) |-> (lo_ff < end_ff))
      else $error("compare with an empty range");

   a_search_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_SEARCH)) |=> busy)
      else $error("search item did not start the sequencer");

endmodule
